### hdl/arith_expression_tokenizer_macros.svh
// Assertion macros shared by the tokenizer modules.
`ifndef ARITH_EXPRESSION_TOKENIZER_MACROS_SVH
`define ARITH_EXPRESSION_TOKENIZER_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define AET_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define AET_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/aet_pkg.sv
// Types and constants shared by the arithmetic expression tokenizer.
`timescale 1ns / 1ps

package aet_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] CAPACITY_RESET = 16'd64;

  // Character codes.
  localparam logic [7:0] CHAR_NUL      = 8'h00;
  localparam logic [7:0] CHAR_DIGIT_LO = 8'd48;
  localparam logic [7:0] CHAR_DIGIT_HI = 8'd57;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
  localparam logic [7:0] CHAR_TAB      = 8'h09;
  localparam logic [7:0] CHAR_PLUS     = 8'h2B;
  localparam logic [7:0] CHAR_MINUS    = 8'h2D;
  localparam logic [7:0] CHAR_STAR     = 8'h2A;
  localparam logic [7:0] CHAR_SLASH    = 8'h2F;
  localparam logic [7:0] CHAR_PERCENT  = 8'h25;
  localparam logic [7:0] CHAR_LPAREN   = 8'h28;
  localparam logic [7:0] CHAR_RPAREN   = 8'h29;

  typedef logic [3:0] kind_t;

  localparam kind_t KIND_NUM    = 4'd0;
  localparam kind_t KIND_ADD    = 4'd1;
  localparam kind_t KIND_SUB    = 4'd2;
  localparam kind_t KIND_MUL    = 4'd3;
  localparam kind_t KIND_DIV    = 4'd4;
  localparam kind_t KIND_REM    = 4'd5;
  localparam kind_t KIND_LPAREN = 4'd6;
  localparam kind_t KIND_RPAREN = 4'd7;
  localparam kind_t KIND_END    = 4'd8;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_SPACE   = 2'd1;
  localparam status_t ST_INVALID = 2'd2;

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_DIGIT,
    CLS_OP,
    CLS_SPACE,
    CLS_OTHER
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    kind_t       kind;
  } char_item_t;

  typedef struct packed {
    kind_t       token_kind;
    status_t     status;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] token_count;
    logic        last;
  } result_t;

endpackage

### hdl/arith_expression_tokenizer.sv
// A character goes through the character queue and the lexer into the result queue.
// Throughput: one character per cycle unless stalled; a character that closes a
// number and also yields a token stays queued; the lexer writes one result per cycle.
// Queues of four entries on each side absorb stalls from either neighbour.
// Reset is synchronous and active low: queues and lexer state clear, capacity is 64.
`timescale 1ns / 1ps

module arith_expression_tokenizer #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_token_capacity,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_char_code,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_token_kind,
  output logic [1:0]  out_status,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [15:0] out_token_count,
  output logic        out_last
);

  aet_pkg::char_item_t item;
  logic                item_empty;
  logic                item_pop;
  aet_pkg::result_t    res;
  logic                res_push;
  logic                res_full;
  aet_pkg::result_t    out_res;

  aet_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_char_code (in_char_code),
    .in_full      (in_full),
    .item_pop     (item_pop),
    .item         (item),
    .item_empty   (item_empty)
  );

  aet_lexer #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_lexer (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_token_capacity (cfg_token_capacity),
    .item               (item),
    .item_empty         (item_empty),
    .item_pop           (item_pop),
    .res                (res),
    .res_push           (res_push),
    .res_full           (res_full)
  );

  aet_queue #(
    .WIDTH ($bits(aet_pkg::result_t)),
    .DEPTH (aet_pkg::QUEUE_DEPTH)
  ) u_result_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_res),
    .empty   (out_empty)
  );

  assign out_token_kind   = out_res.token_kind;
  assign out_status       = out_res.status;
  assign out_token_start  = out_res.token_start;
  assign out_token_length = out_res.token_length;
  assign out_token_count  = out_res.token_count;
  assign out_last         = out_res.last;

endmodule

### hdl/aet_queue.sv
// Small synchronous FIFO used between the tokenizer stages.
`timescale 1ns / 1ps
`include "arith_expression_tokenizer_macros.svh"

module aet_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wr_data;
    end
  end

  `AET_ASSERT_HOLDS(a_count_bound, count_r <= CNT_W'(DEPTH), "queue count exceeds depth")
  `AET_ASSERT_NEXT(a_push_fills, push && !full, !empty, "queue empty after a push")
  `AET_ASSERT_IMPLIES(a_ptr_agree, wr_ptr_r != rd_ptr_r, !empty && !full, "pointers disagree with count")

endmodule

### hdl/aet_front.sv
// Front end: takes character transactions, classifies them and queues them.
`timescale 1ns / 1ps

module aet_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic [7:0]          in_char_code,
  output logic                in_full,
  input  logic                item_pop,
  output aet_pkg::char_item_t item,
  output logic                item_empty
);

  aet_pkg::char_item_t cls_item;

  always_comb begin
    cls_item.kind = aet_pkg::KIND_NUM;
    unique case (in_char_code)
      aet_pkg::CHAR_NUL: cls_item.cls = aet_pkg::CLS_ZERO;
      aet_pkg::CHAR_PLUS: begin
        cls_item.cls  = aet_pkg::CLS_OP;
        cls_item.kind = aet_pkg::KIND_ADD;
      end
      aet_pkg::CHAR_MINUS: begin
        cls_item.cls  = aet_pkg::CLS_OP;
        cls_item.kind = aet_pkg::KIND_SUB;
      end
      aet_pkg::CHAR_STAR: begin
        cls_item.cls  = aet_pkg::CLS_OP;
        cls_item.kind = aet_pkg::KIND_MUL;
      end
      aet_pkg::CHAR_SLASH: begin
        cls_item.cls  = aet_pkg::CLS_OP;
        cls_item.kind = aet_pkg::KIND_DIV;
      end
      aet_pkg::CHAR_PERCENT: begin
        cls_item.cls  = aet_pkg::CLS_OP;
        cls_item.kind = aet_pkg::KIND_REM;
      end
      aet_pkg::CHAR_LPAREN: begin
        cls_item.cls  = aet_pkg::CLS_OP;
        cls_item.kind = aet_pkg::KIND_LPAREN;
      end
      aet_pkg::CHAR_RPAREN: begin
        cls_item.cls  = aet_pkg::CLS_OP;
        cls_item.kind = aet_pkg::KIND_RPAREN;
      end
      aet_pkg::CHAR_SPACE, aet_pkg::CHAR_NEWLINE, aet_pkg::CHAR_TAB: begin
        cls_item.cls = aet_pkg::CLS_SPACE;
      end
      default: begin
        cls_item.cls = (in_char_code >= aet_pkg::CHAR_DIGIT_LO &&
                        in_char_code <= aet_pkg::CHAR_DIGIT_HI) ?
                       aet_pkg::CLS_DIGIT : aet_pkg::CLS_OTHER;
      end
    endcase
  end

  aet_queue #(
    .WIDTH ($bits(aet_pkg::char_item_t)),
    .DEPTH (aet_pkg::QUEUE_DEPTH)
  ) u_char_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (cls_item),
    .full    (in_full),
    .pop     (item_pop),
    .rd_data (item),
    .empty   (item_empty)
  );

endmodule

### hdl/aet_lexer.sv
// Back end: lexer state machine that turns classified characters into tokens.
`timescale 1ns / 1ps
`include "arith_expression_tokenizer_macros.svh"

module aet_lexer #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_token_capacity,
  input  aet_pkg::char_item_t item,
  input  logic                item_empty,
  output logic                item_pop,
  output aet_pkg::result_t    res,
  output logic                res_push,
  input  logic                res_full
);

  typedef enum logic [1:0] {
    PH_BETWEEN,
    PH_NUMBER,
    PH_DROP
  } phase_t;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  phase_t                 phase_r, phase_nxt;
  logic                   seen_r, seen_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [15:0]            tokens_r, tokens_nxt;
  logic [OFFSET_BITS-1:0] num_start_r, num_start_nxt;
  logic [OFFSET_BITS-1:0] num_len_r, num_len_nxt;
  logic [15:0]            limit_r;
  logic                   second_r, second_nxt;

  logic [OFFSET_BITS-1:0] pos_inc;
  logic [OFFSET_BITS-1:0] len_inc;
  logic [15:0]            pos16;
  logic [15:0]            tok_inc;
  logic                   full_now;
  logic                   full_after;
  logic [15:0]            t_base;
  logic                   full_base;
  logic                   common_go;
  logic                   common_emit;
  aet_pkg::result_t       common_res;
  aet_pkg::result_t       res0;
  aet_pkg::result_t       res1;
  logic [1:0]             res_cnt;
  logic                   new_str;
  logic                   item_ok;
  logic                   finish;

  function automatic aet_pkg::result_t make_result(
    input aet_pkg::kind_t   kind,
    input aet_pkg::status_t status,
    input logic [15:0]      start,
    input logic [15:0]      length,
    input logic [15:0]      count,
    input logic             last
  );
    aet_pkg::result_t r;
    r.token_kind   = kind;
    r.status       = status;
    r.token_start  = start;
    r.token_length = length;
    r.token_count  = count;
    r.last         = last;
    return r;
  endfunction

  assign pos_inc    = (pos_r == OFF_MAX) ? pos_r : pos_r + 1'b1;
  assign len_inc    = (num_len_r == OFF_MAX) ? num_len_r : num_len_r + 1'b1;
  assign pos16      = 16'(pos_r);
  assign tok_inc    = tokens_r + 16'd1;
  assign full_now   = (tokens_r == limit_r);
  assign full_after = (tok_inc == limit_r);

  always_comb begin
    phase_nxt     = phase_r;
    seen_nxt      = seen_r;
    pos_nxt       = pos_r;
    tokens_nxt    = tokens_r;
    num_start_nxt = num_start_r;
    num_len_nxt   = num_len_r;
    res0          = '0;
    res1          = '0;
    res_cnt       = 2'd0;
    new_str       = 1'b0;
    common_go     = 1'b0;
    common_emit   = 1'b0;
    common_res    = '0;
    t_base        = tokens_r;
    full_base     = full_now;

    unique case (phase_r)
      PH_DROP: begin
        new_str = (item.cls == aet_pkg::CLS_ZERO);
      end
      PH_NUMBER: begin
        if (full_now) begin
          res0    = make_result(aet_pkg::KIND_END, aet_pkg::ST_SPACE, pos16, 16'd0,
                                tokens_r, 1'b1);
          res_cnt = 2'd1;
          if (item.cls == aet_pkg::CLS_ZERO) begin
            new_str = 1'b1;
          end else begin
            phase_nxt = PH_DROP;
          end
        end else if (item.cls == aet_pkg::CLS_DIGIT) begin
          num_len_nxt = len_inc;
          pos_nxt     = pos_inc;
        end else begin
          // The pending number closes first; the closing byte is handled after it.
          res0       = make_result(aet_pkg::KIND_NUM, aet_pkg::ST_OK, 16'(num_start_r),
                                   16'(num_len_r), 16'd0, 1'b0);
          res_cnt    = 2'd1;
          tokens_nxt = tok_inc;
          phase_nxt  = PH_BETWEEN;
          if (item.cls == aet_pkg::CLS_ZERO) begin
            res1    = make_result(aet_pkg::KIND_END, aet_pkg::ST_OK, 16'd0, 16'd0,
                                  tok_inc, 1'b1);
            res_cnt = 2'd2;
            new_str = 1'b1;
          end else begin
            common_go = 1'b1;
            t_base    = tok_inc;
            full_base = full_after;
          end
        end
      end
      PH_BETWEEN: begin
        if (item.cls == aet_pkg::CLS_ZERO) begin
          if (seen_r) begin
            res0 = make_result(aet_pkg::KIND_END, aet_pkg::ST_OK, 16'd0, 16'd0,
                               tokens_r, 1'b1);
          end else begin
            // An empty string is an error at offset zero.
            res0 = make_result(aet_pkg::KIND_END,
                               full_now ? aet_pkg::ST_SPACE : aet_pkg::ST_INVALID,
                               pos16, 16'd0, tokens_r, 1'b1);
          end
          res_cnt = 2'd1;
          new_str = 1'b1;
        end else begin
          common_go = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_BETWEEN;
      end
    endcase

    if (common_go) begin
      if (full_base) begin
        common_res  = make_result(aet_pkg::KIND_END, aet_pkg::ST_SPACE, pos16, 16'd0,
                                  t_base, 1'b1);
        common_emit = 1'b1;
        phase_nxt   = PH_DROP;
      end else begin
        unique case (item.cls)
          aet_pkg::CLS_DIGIT: begin
            phase_nxt     = PH_NUMBER;
            num_start_nxt = pos_r;
            num_len_nxt   = OFFSET_BITS'(1);
            seen_nxt      = 1'b1;
            pos_nxt       = pos_inc;
          end
          aet_pkg::CLS_OP: begin
            common_res  = make_result(item.kind, aet_pkg::ST_OK, pos16, 16'd1, 16'd0,
                                      1'b0);
            common_emit = 1'b1;
            tokens_nxt  = t_base + 16'd1;
            seen_nxt    = 1'b1;
            pos_nxt     = pos_inc;
          end
          aet_pkg::CLS_SPACE: begin
            seen_nxt = 1'b1;
            pos_nxt  = pos_inc;
          end
          default: begin
            common_res  = make_result(aet_pkg::KIND_END, aet_pkg::ST_INVALID, pos16,
                                      16'd0, t_base, 1'b1);
            common_emit = 1'b1;
            phase_nxt   = PH_DROP;
          end
        endcase
      end
      if (common_emit) begin
        if (res_cnt == 2'd0) begin
          res0    = common_res;
          res_cnt = 2'd1;
        end else begin
          res1    = common_res;
          res_cnt = 2'd2;
        end
      end
    end

    if (new_str) begin
      phase_nxt     = PH_BETWEEN;
      seen_nxt      = 1'b0;
      pos_nxt       = '0;
      tokens_nxt    = '0;
      num_start_nxt = '0;
      num_len_nxt   = '0;
    end
  end

  // A character giving two results holds the queue head until its second result is pushed;
  // the lexer state is committed only once its last result has gone out.
  assign item_ok  = !item_empty && !res_full;
  assign res      = second_r ? res1 : res0;
  assign res_push = item_ok && (res_cnt != 2'd0);
  assign finish   = item_ok && ((res_cnt != 2'd2) || second_r);
  assign item_pop = finish;

  always_comb begin
    second_nxt = second_r;
    if (item_ok) begin
      second_nxt = (res_cnt == 2'd2) && !second_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_BETWEEN;
      seen_r      <= 1'b0;
      pos_r       <= '0;
      tokens_r    <= '0;
      num_start_r <= '0;
      num_len_r   <= '0;
      limit_r     <= aet_pkg::CAPACITY_RESET - 16'd1;
      second_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_token_capacity - 16'd1;
      end
      second_r <= second_nxt;
      if (finish) begin
        phase_r     <= phase_nxt;
        seen_r      <= seen_nxt;
        pos_r       <= pos_nxt;
        tokens_r    <= tokens_nxt;
        num_start_r <= num_start_nxt;
        num_len_r   <= num_len_nxt;
      end
    end
  end

  `AET_ASSERT_IMPLIES(a_second_holds_item, second_r, !item_empty, "second result without item")
  `AET_ASSERT_IMPLIES(a_number_nonempty, phase_r == PH_NUMBER, num_len_r != '0, "empty number")
  `AET_ASSERT_NEXT(a_second_follows, res_push && !second_r && res_cnt == 2'd2, second_r, "second result lost")

endmodule

### tb/aet_token_checker.sv
// Token checker: predicts the tokenizer's results from accepted characters and compares them.
`timescale 1ns / 1ps

module aet_token_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_token_capacity,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [7:0]  in_char_code,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [3:0]  out_token_kind,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_token_start,
  input  logic [15:0] out_token_length,
  input  logic [15:0] out_token_count,
  input  logic        out_last,
  output int          fail_count,
  output int          pending,
  output int          lexed_chars
);

  typedef enum logic [1:0] {
    LEX_BETWEEN,
    LEX_NUMBER,
    LEX_DROP
  } lex_phase_t;

  lex_phase_t  phase;
  logic        seen_char;
  logic [15:0] char_pos;
  logic [15:0] tokens;
  logic [15:0] num_start;
  logic [15:0] num_len;
  logic [15:0] capacity;

  aet_pkg::result_t pending_tokens[$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    lexed_chars = 0;
  end

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // KIND_NUM doubles as "not an operator" here, since no operator maps to it.
  function automatic aet_pkg::kind_t op_kind(input logic [7:0] c);
    unique case (c)
      aet_pkg::CHAR_PLUS:    return aet_pkg::KIND_ADD;
      aet_pkg::CHAR_MINUS:   return aet_pkg::KIND_SUB;
      aet_pkg::CHAR_STAR:    return aet_pkg::KIND_MUL;
      aet_pkg::CHAR_SLASH:   return aet_pkg::KIND_DIV;
      aet_pkg::CHAR_PERCENT: return aet_pkg::KIND_REM;
      aet_pkg::CHAR_LPAREN:  return aet_pkg::KIND_LPAREN;
      aet_pkg::CHAR_RPAREN:  return aet_pkg::KIND_RPAREN;
      default:               return aet_pkg::KIND_NUM;
    endcase
  endfunction

  task automatic restart_string();
    phase     = LEX_BETWEEN;
    seen_char = 1'b0;
    char_pos  = '0;
    tokens    = '0;
    num_start = '0;
    num_len   = '0;
  endtask

  task automatic queue_token(input aet_pkg::kind_t kind, input aet_pkg::status_t st,
                             input logic [15:0] start, input logic [15:0] len,
                             input logic [15:0] cnt, input logic last);
    aet_pkg::result_t r;
    r.token_kind   = kind;
    r.status       = st;
    r.token_start  = start;
    r.token_length = len;
    r.token_count  = cnt;
    r.last         = last;
    pending_tokens.push_back(r);
  endtask

  task automatic lex_char(input logic [7:0] c);
    logic [15:0]    lim;
    logic [15:0]    here;
    logic           is_digit;
    logic           at_limit;
    aet_pkg::kind_t op;
    // A capacity of zero wraps to a limit of 65535, as if it were 65536.
    lim      = capacity - 16'd1;
    here     = char_pos;
    is_digit = (c >= aet_pkg::CHAR_DIGIT_LO) && (c <= aet_pkg::CHAR_DIGIT_HI);
    at_limit = (tokens == lim);
    op       = op_kind(c);
    lexed_chars++;

    if (phase == LEX_DROP) begin
      if (c == aet_pkg::CHAR_NUL) restart_string();
      return;
    end

    if (phase == LEX_NUMBER) begin
      if (at_limit) begin
        queue_token(aet_pkg::KIND_END, aet_pkg::ST_SPACE, here, '0, tokens, 1'b1);
        if (c == aet_pkg::CHAR_NUL) restart_string();
        else phase = LEX_DROP;
        return;
      end
      if (is_digit) begin
        num_len  = sat_inc(num_len);
        char_pos = sat_inc(here);
        return;
      end
      // The pending number is closed first; the closing byte is handled after it.
      queue_token(aet_pkg::KIND_NUM, aet_pkg::ST_OK, num_start, num_len, '0, 1'b0);
      tokens   = tokens + 16'd1;
      phase    = LEX_BETWEEN;
      at_limit = (tokens == lim);
      if (c == aet_pkg::CHAR_NUL) begin
        queue_token(aet_pkg::KIND_END, aet_pkg::ST_OK, '0, '0, tokens, 1'b1);
        restart_string();
        return;
      end
    end else if (c == aet_pkg::CHAR_NUL) begin
      if (seen_char) begin
        queue_token(aet_pkg::KIND_END, aet_pkg::ST_OK, '0, '0, tokens, 1'b1);
      end else begin
        queue_token(aet_pkg::KIND_END, at_limit ? aet_pkg::ST_SPACE : aet_pkg::ST_INVALID,
                    here, '0, tokens, 1'b1);
      end
      restart_string();
      return;
    end

    if (at_limit) begin
      queue_token(aet_pkg::KIND_END, aet_pkg::ST_SPACE, here, '0, tokens, 1'b1);
      phase = LEX_DROP;
      return;
    end
    if (is_digit) begin
      phase     = LEX_NUMBER;
      num_start = here;
      num_len   = 16'd1;
    end else if (op != aet_pkg::KIND_NUM) begin
      queue_token(op, aet_pkg::ST_OK, here, 16'd1, '0, 1'b0);
      tokens = tokens + 16'd1;
    end else if (c != aet_pkg::CHAR_SPACE && c != aet_pkg::CHAR_NEWLINE &&
                 c != aet_pkg::CHAR_TAB) begin
      queue_token(aet_pkg::KIND_END, aet_pkg::ST_INVALID, here, '0, tokens, 1'b1);
      phase = LEX_DROP;
      return;
    end
    seen_char = 1'b1;
    char_pos  = sat_inc(here);
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    aet_pkg::result_t want;
    if (!rst_n) begin
      restart_string();
      capacity = aet_pkg::CAPACITY_RESET;
      pending_tokens.delete();
    end else begin
      if (cfg_wr_en) capacity = cfg_token_capacity;
      if (in_push && !in_full) lex_char(in_char_code);
      if (out_pop && !out_empty) begin
        if (pending_tokens.size() == 0) begin
          $display("%0t: unexpected transaction: expected none, actual kind %0d status %0d",
                   $time, out_token_kind, out_status);
          fail_count++;
        end else begin
          want = pending_tokens.pop_front();
          check_field("token_kind", 16'(want.token_kind), 16'(out_token_kind));
          check_field("status", 16'(want.status), 16'(out_status));
          check_field("token_start", want.token_start, out_token_start);
          check_field("token_length", want.token_length, out_token_length);
          check_field("token_count", want.token_count, out_token_count);
          check_field("last", 16'(want.last), 16'(out_last));
        end
      end
    end
    pending = pending_tokens.size();
  end

endmodule

### tb/tb_arith_expression_tokenizer.sv
// Testbench top: drives character strings and capacity settings into the tokenizer.
`timescale 1ns / 1ps

module tb_arith_expression_tokenizer;

  localparam int SEGMENTS      = 12;
  localparam int CHARS_PER_SEG = 120;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 5000;
  localparam int LONG_DIGITS   = 90;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_token_capacity;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_char_code;
  logic        out_empty;
  logic        out_pop;
  logic [3:0]  out_token_kind;
  logic [1:0]  out_status;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic [15:0] out_token_count;
  logic        out_last;

  int errors;
  int pending;
  int lexed;
  int send_idle;
  int recv_idle;
  int quiet_cycles;

  arith_expression_tokenizer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_token_capacity (cfg_token_capacity),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_char_code       (in_char_code),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_token_kind     (out_token_kind),
    .out_status         (out_status),
    .out_token_start    (out_token_start),
    .out_token_length   (out_token_length),
    .out_token_count    (out_token_count),
    .out_last           (out_last)
  );

  aet_token_checker u_token_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_token_capacity (cfg_token_capacity),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_char_code       (in_char_code),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_token_kind     (out_token_kind),
    .out_status         (out_status),
    .out_token_start    (out_token_start),
    .out_token_length   (out_token_length),
    .out_token_count    (out_token_count),
    .out_last           (out_last),
    .fail_count         (errors),
    .pending            (pending),
    .lexed_chars        (lexed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= recv_idle);
  end

  // Ends the run if no transaction on either side completes for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_arith_expression_tokenizer: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (in_full);
  endtask

  // Waits until every expected token has arrived, then lets the lexer settle on
  // characters that produce nothing.
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [15:0] value);
    drain();
    cfg_wr_en          <= 1'b1;
    cfg_token_capacity <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] legal_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      return 8'($urandom_range(aet_pkg::CHAR_DIGIT_LO, aet_pkg::CHAR_DIGIT_HI));
    end
    if (pick < 80) begin
      unique case ($urandom_range(6))
        0:       return aet_pkg::CHAR_PLUS;
        1:       return aet_pkg::CHAR_MINUS;
        2:       return aet_pkg::CHAR_STAR;
        3:       return aet_pkg::CHAR_SLASH;
        4:       return aet_pkg::CHAR_PERCENT;
        5:       return aet_pkg::CHAR_LPAREN;
        default: return aet_pkg::CHAR_RPAREN;
      endcase
    end
    unique case ($urandom_range(2))
      0:       return aet_pkg::CHAR_SPACE;
      1:       return aet_pkg::CHAR_NEWLINE;
      default: return aet_pkg::CHAR_TAB;
    endcase
  endfunction

  // Mostly well-formed strings; one in ten carries stray bytes that break it.
  task automatic send_string();
    int  len;
    logic noisy;
    noisy = ($urandom_range(9) == 0);
    len   = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 10);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(3) == 0) send_char(8'($urandom_range(1, 255)));
      else send_char(legal_char());
    end
    send_char(aet_pkg::CHAR_NUL);
  endtask

  function automatic logic [15:0] seg_capacity(input int seg);
    unique case (seg)
      1:       return 16'd1;
      2:       return 16'd2;
      3:       return 16'd3;
      4:       return 16'd65535;
      5:       return 16'd4;
      7:       return 16'd5;
      8:       return 16'd0;
      10:      return aet_pkg::CAPACITY_RESET;
      11:      return 16'd2;
      default: return 16'($urandom_range(6, 40));
    endcase
  endfunction

  initial begin
    logic [7:0] directed_chars[$];
    int         seg_start;
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_token_capacity = '0;
    in_push            = 1'b0;
    in_char_code       = '0;
    out_pop            = 1'b0;
    send_idle          = 33;
    recv_idle          = 66;
    quiet_cycles       = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty string, every operator and separator, numbers closed by an operator,
    // by the terminator and by an invalid byte, a blank string, a bad first byte.
    directed_chars = '{aet_pkg::CHAR_NUL,
                       aet_pkg::CHAR_DIGIT_LO, aet_pkg::CHAR_DIGIT_HI, aet_pkg::CHAR_PLUS,
                       aet_pkg::CHAR_MINUS, aet_pkg::CHAR_STAR, aet_pkg::CHAR_SLASH,
                       aet_pkg::CHAR_PERCENT, aet_pkg::CHAR_LPAREN, aet_pkg::CHAR_RPAREN,
                       aet_pkg::CHAR_SPACE, aet_pkg::CHAR_NEWLINE, aet_pkg::CHAR_TAB,
                       aet_pkg::CHAR_DIGIT_LO + 8'd5, aet_pkg::CHAR_DIGIT_LO + 8'd7,
                       aet_pkg::CHAR_NUL,
                       aet_pkg::CHAR_DIGIT_LO + 8'd1, aet_pkg::CHAR_NUL,
                       aet_pkg::CHAR_DIGIT_LO + 8'd8, 8'hFF, aet_pkg::CHAR_DIGIT_LO + 8'd3,
                       aet_pkg::CHAR_NUL,
                       aet_pkg::CHAR_SPACE, aet_pkg::CHAR_NUL,
                       8'h80, aet_pkg::CHAR_NUL};

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      send_idle = (seg < 4) ? 33 : (seg < 8) ? 66 : 0;
      recv_idle = (seg < 4) ? 66 : (seg < 8) ? 33 : 0;
      if (seg == 0) begin
        foreach (directed_chars[i]) send_char(directed_chars[i]);
      end else begin
        set_capacity(seg_capacity(seg));
      end
      // One number far longer than the random strings produce.
      if (seg == 8) begin
        for (int i = 0; i < LONG_DIGITS; i++)
          send_char(8'($urandom_range(aet_pkg::CHAR_DIGIT_LO, aet_pkg::CHAR_DIGIT_HI)));
        send_char(aet_pkg::CHAR_PLUS);
        send_char(aet_pkg::CHAR_NUL);
      end
      seg_start = lexed;
      while (lexed - seg_start < CHARS_PER_SEG) send_string();
    end

    drain();
    if (errors == 0) begin
      $display("tb_arith_expression_tokenizer: clean");
    end else begin
      $display("tb_arith_expression_tokenizer: errors");
    end
    $finish;
  end

endmodule
